[rtl/elln_pkg.sv]
package elln_pkg;

  localparam int EMBED_DIM = 64;
  localparam int VOCAB_SIZE = 256;
  localparam int COL_W = $clog2(EMBED_DIM);
  localparam int ROW_W = $clog2(VOCAB_SIZE);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int INV_DEPTH = 256;
  localparam int SUM_W = 8 + COL_W + 1;
  localparam int SQ_W = 18 + COL_W;

  localparam logic [2:0] OP_WR_TABLE = 3'd0;
  localparam logic [2:0] OP_WR_GAIN = 3'd1;
  localparam logic [2:0] OP_WR_BIAS = 3'd2;
  localparam logic [2:0] OP_WR_INV = 3'd3;
  localparam logic [2:0] OP_TOKEN = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MEAN,
    ST_SQ,
    ST_VAR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic rd;
    logic [COL_W-1:0] col;
    logic acc_sum;
    logic acc_sq;
    logic take_mean;
    logic take_var;
    logic take_inv;
    logic emit;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

[rtl/embedding_lookup_int8_layer_norm_unit.sv]
// Flow: a token runs a sum pass, a mean step, a square pass, variance and inverse
// steps, then emits the words in order. The input stalls for the whole run, so no new
// token or write is taken before the last word is issued; only one word is in flight,
// set by the single-word output register. Writes are taken whenever the block is idle.
// Reset: rst synchronous active high clears control and mean/scale; stores keep
// undefined content until written.
module embedding_lookup_int8_layer_norm_unit
  import elln_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        opcode,
  input  logic [7:0]        row_index,
  input  logic [5:0]        column,
  input  logic [7:0]        write_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        element_index,
  output logic signed [7:0] out_value,
  output logic              last_flag
);

  logic busy, acc, start;
  cmd_t cmd;
  sts_t sts;

  assign in_stall = busy;
  assign acc = in_valid & !busy;
  assign start = acc & (opcode == OP_TOKEN);

  elln_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
  );

  elln_dp u_dp (
    .clk(clk), .rst(rst), .wr_valid(acc), .wr_op(opcode), .wr_row(row_index),
    .wr_col(column), .wr_data(write_data), .tok_start(start), .cmd(cmd),
    .sts(sts), .o_valid(out_valid), .o_stall(out_stall),
    .o_index(element_index), .o_value(out_value), .o_last(last_flag)
  );

endmodule

[rtl/elln_ctrl.sv]
module elln_ctrl
  import elln_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sts_t             sts,
  output logic             busy,
  output cmd_t             cmd
);

  state_t state, state_next;
  logic [COL_W:0] cnt, cnt_next;
  logic [1:0] wait_cnt, wait_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      wait_cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      wait_cnt <= wait_cnt_next;
    end
  end

  // read issued at cnt, data back in the next cycle (cnt-1 consumed)
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    wait_cnt_next = wait_cnt;
    cmd = '0;
    cmd.col = cnt[COL_W-1:0];
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.clr = 1'b1;
          state_next = ST_SUM;
          cnt_next = '0;
        end
      end
      ST_SUM: begin
        cmd.rd = (cnt < (COL_W+1)'(EMBED_DIM));
        cmd.acc_sum = (cnt != '0);
        cnt_next = cnt + 1'b1;
        if (cnt == (COL_W+1)'(EMBED_DIM)) begin
          state_next = ST_MEAN;
          cnt_next = '0;
        end
      end
      ST_MEAN: begin
        cmd.take_mean = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.rd = (cnt < (COL_W+1)'(EMBED_DIM));
        cmd.acc_sq = (cnt != '0);
        cnt_next = cnt + 1'b1;
        if (cnt == (COL_W+1)'(EMBED_DIM)) begin
          state_next = ST_VAR;
          cnt_next = '0;
          wait_cnt_next = '0;
        end
      end
      ST_VAR: begin
        wait_cnt_next = wait_cnt + 1'b1;
        cmd.take_var = (wait_cnt == 2'd0);
        cmd.take_inv = (wait_cnt == 2'd2);
        if (wait_cnt == 2'd2) begin
          state_next = ST_EMIT;
          cnt_next = '0;
        end
      end
      ST_EMIT: begin
        // one element per step, gated by the output register
        if (!sts.out_busy) begin
          cmd.rd = 1'b1;
          cmd.emit = 1'b1;
          cmd.last = (cnt == (COL_W+1)'(EMBED_DIM - 1));
          cnt_next = cnt + 1'b1;
          if (cmd.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !sts.out_busy) else $error("emit while output busy");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.last |=> state == ST_IDLE) else $error("last did not end run");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= (COL_W+1)'(EMBED_DIM)) else $error("counter overrun");
`endif

endmodule

[rtl/elln_dp.sv]
module elln_dp
  import elln_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  input  logic [2:0]        wr_op,
  input  logic [7:0]        wr_row,
  input  logic [5:0]        wr_col,
  input  logic [7:0]        wr_data,
  input  logic              tok_start,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              o_valid,
  input  logic              o_stall,
  output logic [5:0]        o_index,
  output logic signed [7:0] o_value,
  output logic              o_last
);

  logic [7:0] emb_mem [VOCAB_SIZE*EMBED_DIM];
  logic [7:0] gain_mem [EMBED_DIM];
  logic [7:0] bias_mem [EMBED_DIM];
  logic [7:0] inv_mem [INV_DEPTH];

  logic [ROW_W-1:0] tok_row;
  logic [7:0] emb_q, gain_q, bias_q, inv_q;
  logic [7:0] inv_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic signed [SUM_W-1:0] sum;
  logic signed [SQ_W-1:0] sq;
  logic signed [8:0] mean;
  logic [7:0] var_q;
  logic [7:0] inv_scale;
  logic [7:0] mean_value;

  // emit pipeline
  logic e1_v, e1_last;
  logic [5:0] e1_idx;
  logic signed [16:0] e1_prod;
  logic [7:0] e1_bias;
  logic signed [8:0] d_rd;
  logic signed [17:0] d_sq;

  assign wr_addr = {wr_row[ROW_W-1:0], wr_col[COL_W-1:0]};
  assign d_rd = $signed({emb_q[7], emb_q}) - mean;

  always_ff @(posedge clk) begin
    if (wr_valid && wr_op == OP_WR_TABLE && {1'b0, wr_col} < 7'(EMBED_DIM)) begin
      emb_mem[wr_addr] <= wr_data;
    end
    if (tok_start) begin
      tok_row <= wr_row[ROW_W-1:0];
    end
    emb_q <= emb_mem[{tok_row, cmd.col}];
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_op == OP_WR_GAIN && {1'b0, wr_col} < 7'(EMBED_DIM)) begin
      gain_mem[wr_col[COL_W-1:0]] <= wr_data;
    end
    if (wr_valid && wr_op == OP_WR_BIAS && {1'b0, wr_col} < 7'(EMBED_DIM)) begin
      bias_mem[wr_col[COL_W-1:0]] <= wr_data;
    end
    gain_q <= gain_mem[cmd.col];
    bias_q <= bias_mem[cmd.col];
  end

  assign inv_addr = (wr_valid && wr_op == OP_WR_INV) ? wr_row : var_q;

  always_ff @(posedge clk) begin
    if (wr_valid && wr_op == OP_WR_INV) begin
      inv_mem[wr_row] <= wr_data;
    end
    inv_q <= inv_mem[inv_addr];
  end

  assign d_sq = d_rd * d_rd;

  // accumulate; division by power of two truncating toward zero
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_value <= '0;
      inv_scale <= '0;
      sum <= '0;
      sq <= '0;
      mean <= '0;
      var_q <= '0;
    end else begin
      if (cmd.clr) begin
        sum <= '0;
        sq <= '0;
      end
      if (cmd.acc_sum) begin
        sum <= sum + SUM_W'($signed(emb_q));
      end
      if (cmd.take_mean) begin
        if (sum < 0) begin
          mean <= 9'(-((-sum) >>> COL_W));
          mean_value <= 8'(-((-sum) >>> COL_W));
        end else begin
          mean <= 9'(sum >>> COL_W);
          mean_value <= 8'(sum >>> COL_W);
        end
      end
      if (cmd.acc_sq) begin
        sq <= sq + SQ_W'(d_sq);
      end
      if (cmd.take_var) begin
        var_q <= ((sq >>> COL_W) > 255) ? 8'd255 : 8'(sq >>> COL_W);
      end
      if (cmd.take_inv) begin
        inv_scale <= inv_q;
      end
    end
  end

  // stage 1: d*gain, stage 2: scale, norm, bias, clamp
  logic signed [24:0] s2_prod;
  logic signed [9:0] scaled;
  logic signed [17:0] n_pre;
  logic signed [9:0] n_clip;
  logic signed [10:0] v_sum;
  logic s_emit, s_last;
  logic [5:0] s_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_emit <= 1'b0;
      e1_v <= 1'b0;
    end else begin
      s_emit <= cmd.emit;
      e1_v <= s_emit;
    end
    s_last <= cmd.last;
    s_idx <= 6'(cmd.col);
    e1_prod <= d_rd * $signed(gain_q);
    e1_bias <= bias_q;
    e1_idx <= s_idx;
    e1_last <= s_last;
  end

  always_comb begin
    scaled = 10'((e1_prod + 17'sd64) >>> 7);
    s2_prod = 25'(scaled) * $signed({1'b0, inv_scale}) + 25'sd128;
    n_pre = 18'(s2_prod >>> 8);
    // |n_pre| < 2^15 always; keep margin then bias
    if (n_pre > 18'sd511) n_clip = 10'sd511;
    else if (n_pre < -18'sd512) n_clip = -10'sd512;
    else n_clip = 10'(n_pre);
    v_sum = 11'(n_clip) + 11'($signed(e1_bias));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (e1_v) begin
      o_valid <= 1'b1;
    end else if (!o_stall) begin
      o_valid <= 1'b0;
    end
    if (e1_v) begin
      o_index <= e1_idx;
      o_last <= e1_last;
      if (v_sum > 11'sd127) o_value <= 8'sd127;
      else if (v_sum < -11'sd128) o_value <= -8'sd128;
      else o_value <= 8'(v_sum);
    end
  end

  // a word in flight or held blocks the next issue
  assign sts.out_busy = s_emit | e1_v | (o_valid & o_stall);

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    e1_v |-> !(o_valid && o_stall)) else $error("output word overwritten");
  a_one_flight: assert property (@(posedge clk) disable iff (rst)
    s_emit |-> !e1_v) else $error("two words in flight");
  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_last && !o_stall) |=> !o_valid) else $error("word after last");
`endif

endmodule

[sim/elln_checker.sv]
module elln_checker
  import elln_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        opcode,
  input  logic [7:0]        row_index,
  input  logic [5:0]        column,
  input  logic [7:0]        write_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [5:0]        element_index,
  input  logic signed [7:0] out_value,
  input  logic              last_flag,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]        idx;
    logic signed [7:0] val;
    logic              last;
  } norm_word_t;

  logic signed [7:0] embed_mem [VOCAB_SIZE*EMBED_DIM];
  logic signed [7:0] gain_mem [EMBED_DIM];
  logic signed [7:0] bias_mem [EMBED_DIM];
  logic [7:0]        inv_mem [INV_DEPTH];
  norm_word_t        norm_q [$];

  function automatic int floor_div(int x, int n);
    return x >>> n;
  endfunction

  function automatic int clip(int x, int lo, int hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  task automatic normalise_row(input logic [7:0] row);
    int sum, sq, mu, dev, var_i, inv, scaled, normed, v;
    norm_word_t w;
    sum = 0;
    sq = 0;
    for (int j = 0; j < EMBED_DIM; j++) sum += embed_mem[row*EMBED_DIM+j];
    mu = sum / EMBED_DIM;
    for (int j = 0; j < EMBED_DIM; j++) begin
      dev = embed_mem[row*EMBED_DIM+j] - mu;
      sq += dev * dev;
    end
    var_i = clip(sq / EMBED_DIM, 0, 255);
    inv = inv_mem[var_i];
    for (int j = 0; j < EMBED_DIM; j++) begin
      dev = embed_mem[row*EMBED_DIM+j] - mu;
      scaled = floor_div(dev * gain_mem[j] + 64, 7);
      normed = clip(floor_div(scaled * inv + 128, 8), -32768, 32767);
      v = clip(normed + bias_mem[j], -128, 127);
      w.idx = j[5:0];
      w.val = v[7:0];
      w.last = (j == EMBED_DIM - 1);
      norm_q.push_back(w);
    end
  endtask

  task automatic report(input string what);
    $display("%0t: %s", $time, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    norm_word_t e;
    if (!rst && in_valid && !in_stall) begin
      case (opcode)
        OP_WR_TABLE: embed_mem[{row_index, column}] = write_data;
        OP_WR_GAIN:  gain_mem[column] = write_data;
        OP_WR_BIAS:  bias_mem[column] = write_data;
        OP_WR_INV:   inv_mem[row_index] = write_data;
        OP_TOKEN:    normalise_row(row_index);
        default: ;
      endcase
    end
    if (!rst && out_valid && !out_stall) begin
      if (norm_q.size() == 0) begin
        report($sformatf("unexpected word idx %0d val %0d", element_index, out_value));
      end else begin
        e = norm_q.pop_front();
        if (element_index !== e.idx)
          report($sformatf("element_index %0d, want %0d", element_index, e.idx));
        if (out_value !== e.val)
          report($sformatf("out_value %0d, want %0d (idx %0d)", out_value, e.val, e.idx));
        if (last_flag !== e.last)
          report($sformatf("last_flag %0b, want %0b (idx %0d)", last_flag, e.last, e.idx));
      end
    end
    pending <= norm_q.size();
  end
endmodule

[sim/tb_embedding_lookup_int8_layer_norm_unit.sv]
module tb_embedding_lookup_int8_layer_norm_unit;
  import elln_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  // small-spread row keeps the variance below INV_FILL, the wide row clamps to 255
  localparam int INV_FILL = 64;
  localparam logic [7:0] ROW_WIDE = 8'd255;
  localparam logic [7:0] ROW_SMALL = 8'd0;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        opcode;
  logic [7:0]        row_index;
  logic [5:0]        column;
  logic [7:0]        write_data;
  logic              out_valid;
  logic              out_stall;
  logic [5:0]        element_index;
  logic signed [7:0] out_value;
  logic              last_flag;
  int                fail_count;
  int                pending;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_cycles;
  int                quiet;

  embedding_lookup_int8_layer_norm_unit dut (.*);

  elln_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_stall = 1;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send(input logic [2:0] op, input logic [7:0] row, input logic [5:0] col,
                      input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    row_index <= row;
    column <= col;
    write_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic load_row(input logic [7:0] row, input int mode);
    logic [7:0] b;
    for (int c = 0; c < EMBED_DIM; c++) begin
      case (mode)
        0: b = 8'($urandom);
        1: b = (c % 2) ? 8'h7f : 8'h80;
        2: b = 8'h7f;
        3: b = 8'h80;
        default: b = 8'($urandom_range(7) - 4);
      endcase
      send(OP_WR_TABLE, row, c[5:0], b);
    end
  endtask

  task automatic random_phase(input int n);
    int k;
    logic [7:0] r;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      r = $urandom_range(1) ? ROW_WIDE : ROW_SMALL;
      if (k < 45) send(OP_TOKEN, r, 6'($urandom), 8'($urandom));
      else if (k < 60) send(OP_WR_GAIN, 8'($urandom), 6'($urandom), 8'($urandom));
      else if (k < 72) send(OP_WR_BIAS, 8'($urandom), 6'($urandom), 8'($urandom));
      else if (k < 85) send(OP_WR_INV, 8'($urandom), 6'($urandom), 8'($urandom));
      else if (k < 93) begin
        if (r == ROW_WIDE) send(OP_WR_TABLE, r, 6'($urandom), 8'($urandom));
        else send(OP_WR_TABLE, r, 6'($urandom), 8'($urandom_range(7) - 4));
      end else begin
        send(3'(OP_FIRST_UNUSED + $urandom_range(2)), 8'($urandom), 6'($urandom),
             8'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    opcode = 0;
    row_index = 0;
    column = 0;
    write_data = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int i = 0; i < INV_FILL; i++) send(OP_WR_INV, i[7:0], 6'd0, 8'($urandom));
    send(OP_WR_INV, 8'd255, 6'd0, 8'hff);
    for (int c = 0; c < EMBED_DIM; c++) begin
      send(OP_WR_GAIN, 8'd0, c[5:0], (c == 0) ? 8'h80 : (c == 1) ? 8'h7f : 8'($urandom));
      send(OP_WR_BIAS, 8'd0, c[5:0], (c == 0) ? 8'h7f : (c == 1) ? 8'h80 : 8'($urandom));
    end
    load_row(ROW_WIDE, 1);
    load_row(ROW_SMALL, 4);

    // directed: extreme row, wide inv, unused opcodes, high row id
    send(OP_WR_INV, 8'd0, 6'd0, 8'hff);
    send(OP_TOKEN, ROW_WIDE, 6'h3f, 8'hff);
    send(OP_TOKEN, ROW_SMALL, 6'd0, 8'd0);
    send(OP_FIRST_UNUSED, 8'd1, 6'd0, 8'd0);
    send(3'(OP_FIRST_UNUSED + 1), 8'd1, 6'd0, 8'd0);
    send(3'(OP_FIRST_UNUSED + 2), 8'hff, 6'h3f, 8'hff);
    send(OP_TOKEN, ROW_WIDE, 6'd0, 8'd0);
    drain();

    // long receiver hold-off so the block backs up
    hold_cycles = 1500;
    send(OP_TOKEN, ROW_SMALL, 6'd0, 8'd0);
    send(OP_TOKEN, ROW_WIDE, 6'd0, 8'd0);
    send(OP_TOKEN, ROW_SMALL, 6'd0, 8'd0);
    drain();

    send_idle_pct = 35;
    recv_idle_pct = 84;
    random_phase(17);
    drain();
    send_idle_pct = 84;
    recv_idle_pct = 35;
    random_phase(17);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(17);
    drain();

    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

[sim.f]
rtl/elln_pkg.sv
rtl/elln_ctrl.sv
rtl/elln_dp.sv
rtl/embedding_lookup_int8_layer_norm_unit.sv
sim/elln_checker.sv
sim/tb_embedding_lookup_int8_layer_norm_unit.sv
